@@ rtl/core/zgrle_pkg.sv @@
// ----------------------------------------------------------------------------
// zgrle_pkg
// Shared widths, codes and controller/datapath interface types for the
// zigzag Elias-gamma run-length encoder.
// ----------------------------------------------------------------------------
package zgrle_pkg;

   // Accumulator holds up to 38 leftover bits plus a 31-bit run code.
   localparam int unsigned ACC_W   = 72;
   localparam int unsigned PEND_W  = 7;
   localparam int unsigned CODE_W  = 16;
   localparam int unsigned RUN_W   = 16;
   localparam int unsigned LEN_W   = 4;
   localparam int unsigned SHIFT_W = 5;

   localparam logic             ACTION_SAMPLE = 1'b0;
   localparam logic             ACTION_FINISH = 1'b1;
   localparam logic [CODE_W-1:0] REJECT_SAMPLE = 16'h8000;
   localparam logic [PEND_W-1:0] BYTE_BITS     = 7'd8;

   typedef struct packed {
      logic load;        // capture input item
      logic run_inc;     // count one more copy
      logic set_prev;    // previous code <= current code
      logic append_run;  // append gamma code of run count
      logic run_clear;
      logic append_v;    // append gamma code of current code
      logic flush_byte;  // drop top whole byte
      logic clear_all;   // end of stream
   } cmd_type;

   typedef struct packed {
      logic             is_finish;
      logic             is_reject;
      logic             code_match;
      logic             run_zero;
      logic             run_below_limit;
      logic             pend_ge8;
      logic             pend_zero;
      logic             last_byte;   // top byte is the final whole byte
      logic [7:0]       flush_byte;
      logic [7:0]       pad_byte;
   } status_type;

endpackage

@@ rtl/core/zgrle_dp.sv @@
// ----------------------------------------------------------------------------
// zgrle_dp
// Datapath: item capture, zigzag map, run state, bit accumulator with a
// shared gamma append unit and byte extraction.
// ----------------------------------------------------------------------------
module zgrle_dp #(
   parameter int unsigned RUN_LIMIT = 65533
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_action,
   input  logic signed [15:0]               req_sample,
   input  zgrle_pkg::cmd_type               cmd,
   output zgrle_pkg::status_type            status
);

   logic [zgrle_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [zgrle_pkg::PEND_W-1:0]  pend_ff, pend_in;
   logic [zgrle_pkg::CODE_W-1:0]  prev_ff, prev_in;
   logic [zgrle_pkg::RUN_W-1:0]   run_ff, run_in;
   logic [zgrle_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                          finish_ff, finish_in;
   logic                          reject_ff, reject_in;

   logic [zgrle_pkg::CODE_W-1:0]  raw;
   logic [zgrle_pkg::CODE_W-1:0]  zz;
   logic [zgrle_pkg::CODE_W-1:0]  operand;
   logic [zgrle_pkg::LEN_W-1:0]   len;
   logic [zgrle_pkg::SHIFT_W-1:0] shift;
   logic [zgrle_pkg::PEND_W-1:0]  pend_less8;

   function automatic logic [zgrle_pkg::LEN_W-1:0] msb_index(
      input logic [zgrle_pkg::CODE_W-1:0] t);
      logic [zgrle_pkg::LEN_W-1:0] r;
      r = '0;
      for (int i = 1; i < zgrle_pkg::CODE_W; i++) begin
         if (t[i]) begin
            r = zgrle_pkg::LEN_W'(i);
         end
      end
      return r;
   endfunction

   assign raw = req_sample;
   assign zz  = {raw[zgrle_pkg::CODE_W-2:0], 1'b0} ^ {zgrle_pkg::CODE_W{raw[15]}};

   assign operand    = cmd.append_run ? run_ff : code_ff;
   assign len        = msb_index(operand);
   assign shift      = {len, 1'b1};
   assign pend_less8 = pend_ff - zgrle_pkg::BYTE_BITS;

   always_comb begin
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      prev_in   = prev_ff;
      run_in    = run_ff;
      code_in   = code_ff;
      finish_in = finish_ff;
      reject_in = reject_ff;
      if (cmd.load) begin
         code_in   = zz + 16'd1;
         finish_in = (req_action == zgrle_pkg::ACTION_FINISH);
         reject_in = (raw == zgrle_pkg::REJECT_SAMPLE);
      end
      if (cmd.run_inc) begin
         run_in = run_ff + 16'd1;
      end
      if (cmd.set_prev) begin
         prev_in = code_ff;
      end
      if (cmd.run_clear) begin
         run_in = '0;
      end
      if (cmd.append_run || cmd.append_v) begin
         acc_in  = (acc_ff << shift) | zgrle_pkg::ACC_W'(operand);
         pend_in = pend_ff + zgrle_pkg::PEND_W'(shift);
      end
      if (cmd.flush_byte) begin
         pend_in = pend_less8;
      end
      if (cmd.clear_all) begin
         acc_in  = '0;
         pend_in = '0;
         prev_in = '0;
         run_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
         prev_ff <= '0;
         run_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         prev_ff <= prev_in;
         run_ff  <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      finish_ff <= finish_in;
      reject_ff <= reject_in;
   end

   always_comb begin
      status.is_finish       = finish_ff;
      status.is_reject       = reject_ff;
      status.code_match      = (code_ff == prev_ff);
      status.run_zero        = (run_ff == '0);
      status.run_below_limit = (run_ff < zgrle_pkg::RUN_W'(RUN_LIMIT));
      status.pend_ge8        = (pend_ff >= zgrle_pkg::BYTE_BITS);
      status.pend_zero       = (pend_ff == '0);
      status.last_byte       = (pend_less8 < zgrle_pkg::BYTE_BITS);
      status.flush_byte      = 8'(acc_ff >> pend_less8);
      status.pad_byte        = 8'(acc_ff[7:0] << (zgrle_pkg::BYTE_BITS - pend_ff));
   end

endmodule

@@ rtl/core/zgrle_ctrl.sv @@
// ----------------------------------------------------------------------------
// zgrle_ctrl
// Controller: sequences one item through run decision, gamma appends and
// byte flushing, and owns the result output register.
// ----------------------------------------------------------------------------
module zgrle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_item,
   output logic                   rsp_end_of_stream,
   output logic                   rsp_rejected,
   output zgrle_pkg::cmd_type     cmd,
   input  zgrle_pkg::status_type  status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPEND_RUN,
      ST_FLUSH,
      ST_APPEND_V,
      ST_REJECT,
      ST_PAD,
      ST_TERM
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       rsp_eos_ff;
   logic       rsp_rej_ff;

   logic       slot_free;
   logic       emit;
   logic [7:0] emit_byte;
   logic       emit_last;
   logic       emit_eos;
   logic       emit_rej;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      emit      = 1'b0;
      emit_byte = '0;
      emit_last = 1'b0;
      emit_eos  = 1'b0;
      emit_rej  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (status.is_finish) begin
               state_in = status.run_zero ? ST_FLUSH : ST_APPEND_RUN;
            end else if (status.is_reject) begin
               state_in = ST_REJECT;
            end else if (status.code_match && status.run_below_limit) begin
               cmd.run_inc = 1'b1;
               state_in    = status.run_zero ? ST_FLUSH : ST_IDLE;
            end else begin
               cmd.set_prev = 1'b1;
               state_in     = status.run_zero ? ST_FLUSH : ST_APPEND_RUN;
            end
         end
         ST_APPEND_RUN: begin
            cmd.append_run = 1'b1;
            cmd.run_clear  = 1'b1;
            state_in       = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (status.pend_ge8) begin
               if (slot_free) begin
                  cmd.flush_byte = 1'b1;
                  emit           = 1'b1;
                  emit_byte      = status.flush_byte;
                  emit_last      = !status.is_finish && status.last_byte;
               end
            end else if (!status.is_finish) begin
               state_in = ST_APPEND_V;
            end else begin
               state_in = status.pend_zero ? ST_TERM : ST_PAD;
            end
         end
         ST_APPEND_V: begin
            cmd.append_v = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_REJECT: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               emit_rej  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = status.pad_byte;
               state_in  = ST_TERM;
            end
         end
         ST_TERM: begin
            if (slot_free) begin
               emit          = 1'b1;
               emit_last     = 1'b1;
               emit_eos      = 1'b1;
               cmd.clear_all = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
         rsp_eos_ff  <= emit_eos;
         rsp_rej_ff  <= emit_rej;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_item  = rsp_last_ff;
   assign rsp_end_of_stream = rsp_eos_ff;
   assign rsp_rejected      = rsp_rej_ff;

endmodule

@@ rtl/core/zigzag_elias_gamma_rle_encoder_top.sv @@
// ----------------------------------------------------------------------------
// zigzag_elias_gamma_rle_encoder_top
// Zigzag-mapped Elias-gamma byte encoder with run-length coding of repeats.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_ready  action, sample
//   rsp_     out  rsp_valid/rsp_ready  out_byte, last_of_item,
//                                      end_of_stream, rejected
//
// An item passes through acceptance and the run decision, then up to two gamma
// appends and its result bytes, one per flush step; a counted repeat that extends
// a nonzero run returns after the run decision, a rejection after its one byte.
// The result byte register limits output to one byte per cycle.
// A stalled rsp_ready holds the controller in its current emit state.
// Synchronous reset clears the accumulator, run state and controller.
// ----------------------------------------------------------------------------
module zigzag_elias_gamma_rle_encoder_top #(
   parameter int unsigned RUN_LIMIT = 65533
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_item,
   output logic               rsp_end_of_stream,
   output logic               rsp_rejected
);

   zgrle_pkg::cmd_type    cmd;
   zgrle_pkg::status_type status;

   zgrle_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_rejected      (rsp_rejected),
      .cmd               (cmd),
      .status            (status)
   );

   zgrle_dp #(
      .RUN_LIMIT (RUN_LIMIT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_action (req_action),
      .req_sample (req_sample),
      .cmd        (cmd),
      .status     (status)
   );

   a_eos_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_stream |-> rsp_last_of_item && !rsp_rejected)
      else $error("terminator item not marked last");

   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_last_of_item && rsp_out_byte == 8'd0)
      else $error("rejection item malformed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while item in progress");

   a_eos_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_stream |-> rsp_out_byte == 8'd0)
      else $error("terminator byte not zero");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed samples and finish items into the zigzag Elias-gamma
// run-length encoder and checks every output byte against an in-bench
// bit-accurate encoder. Covers extremes, rejects, runs and finish with a
// pending run, under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned RUN_LIMIT   = 65533;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned TAIL_CYCLES = 40;

   typedef struct {
      logic        action;
      logic [15:0] sample;
      logic        drain_first;
   } sample_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
      logic       eos;
      logic       rej;
   } coded_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = zgrle_pkg::ACTION_SAMPLE;
   logic signed [15:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_last_of_item;
   logic               rsp_end_of_stream;
   logic               rsp_rejected;

   sample_item_type sample_queue[$];
   coded_byte_type  due_bytes[$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // encoder state
   logic [63:0] acc_bits;
   int unsigned acc_count;
   logic [15:0] last_code;
   logic [15:0] repeat_count;

   zigzag_elias_gamma_rle_encoder_top #(
      .RUN_LIMIT(RUN_LIMIT)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_rejected      (rsp_rejected)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void emit_byte(logic [7:0] b, logic eos, logic rej);
      coded_byte_type r;
      r.out_byte = b;
      r.last     = 1'b0;
      r.eos      = eos;
      r.rej      = rej;
      due_bytes.push_back(r);
   endfunction

   function automatic void flush_whole_bytes();
      while (acc_count >= 8) begin
         acc_count -= 8;
         emit_byte(8'(acc_bits >> acc_count), 1'b0, 1'b0);
      end
   endfunction

   function automatic void append_gamma(logic [15:0] v);
      int unsigned nbits;
      logic [15:0] t;
      nbits = 0;
      t = v;
      flush_whole_bytes();
      while (t > 16'd1) begin
         nbits++;
         t >>= 1;
      end
      acc_bits  = (acc_bits << (2 * nbits + 1)) | 64'(v);
      acc_count += 2 * nbits + 1;
   endfunction

   function automatic void clear_encoder();
      acc_bits     = '0;
      acc_count    = 0;
      last_code    = '0;
      repeat_count = '0;
   endfunction

   function automatic void encode_item(logic action, logic [15:0] sample);
      int unsigned first;
      logic [15:0] v;
      first = due_bytes.size();
      if (action == zgrle_pkg::ACTION_FINISH) begin
         if (repeat_count != 0) append_gamma(repeat_count);
         flush_whole_bytes();
         if (acc_count != 0) emit_byte(8'(acc_bits << (8 - acc_count)), 1'b0, 1'b0);
         emit_byte(8'h00, 1'b1, 1'b0);
         clear_encoder();
      end else if (sample == zgrle_pkg::REJECT_SAMPLE) begin
         emit_byte(8'h00, 1'b0, 1'b1);
      end else begin
         v = ((sample << 1) ^ {16{sample[15]}}) + 16'd1;
         if (v == last_code && repeat_count < RUN_LIMIT) begin
            repeat_count++;
            if (repeat_count == 16'd1) append_gamma(v);
         end else begin
            if (repeat_count != 0) append_gamma(repeat_count);
            repeat_count = '0;
            last_code    = v;
            append_gamma(v);
         end
      end
      if (due_bytes.size() > first) due_bytes[due_bytes.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic add_item(logic action, logic [15:0] sample, logic drain_first);
      sample_item_type it;
      it.action      = action;
      it.sample      = sample;
      it.drain_first = drain_first;
      sample_queue.push_back(it);
   endtask

   // well-formed mix: runs of repeats, small values, full-range values,
   // rejects and finishes
   task automatic fill_random(int unsigned count);
      int unsigned added;
      int unsigned pick;
      int unsigned reps;
      logic [15:0] prior;
      added = 0;
      prior = '0;
      while (added < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            add_item(zgrle_pkg::ACTION_FINISH, 16'($urandom), 1'b0);
            added++;
         end else if (pick < 12) begin
            add_item(zgrle_pkg::ACTION_SAMPLE, zgrle_pkg::REJECT_SAMPLE, 1'b0);
            added++;
         end else if (pick < 40) begin
            reps = $urandom_range(6, 1);
            repeat (reps) add_item(zgrle_pkg::ACTION_SAMPLE, prior, 1'b0);
            added += reps;
         end else begin
            if (pick < 75) prior = 16'(int'($urandom_range(16)) - 8);
            else prior = 16'($urandom);
            add_item(zgrle_pkg::ACTION_SAMPLE, prior, 1'b0);
            added++;
         end
      end
   endtask

   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_valid || due_bytes.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : drive
      logic            offer;
      sample_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) encode_item(req_action, req_sample);
         if (!req_valid || req_ready) begin
            offer = 1'b0;
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
               offer = !(sample_queue[0].drain_first && due_bytes.size() != 0);
            if (offer) begin
               nxt = sample_queue.pop_front();
               req_action <= nxt.action;
               req_sample <= nxt.sample;
            end
            req_valid <= offer;
         end
      end
   end

   always @(posedge clock) begin : watch
      coded_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_bytes.size() == 0) begin
               report_mismatch("result with none due", rsp_out_byte, 0);
            end else begin
               want = due_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, want.out_byte);
               if (rsp_last_of_item !== want.last)
                  report_mismatch("last_of_item", rsp_last_of_item, want.last);
               if (rsp_end_of_stream !== want.eos)
                  report_mismatch("end_of_stream", rsp_end_of_stream, want.eos);
               if (rsp_rejected !== want.rej)
                  report_mismatch("rejected", rsp_rejected, want.rej);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      clear_encoder();
      send_idle_pct = 15;
      rsp_stall_pct = 76;

      add_item(zgrle_pkg::ACTION_FINISH, 16'h0000, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd0, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, -16'sd1, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd1, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd32767, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, -16'sd32767, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, zgrle_pkg::REJECT_SAMPLE, 1'b0);
      repeat (5) add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd3, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, -16'sd4, 1'b0);
      repeat (3) add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd3, 1'b0);
      add_item(zgrle_pkg::ACTION_FINISH, 16'hFFFF, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd7, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd7, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, zgrle_pkg::REJECT_SAMPLE, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd7, 1'b0);
      add_item(zgrle_pkg::ACTION_FINISH, 16'h0000, 1'b0);
      add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd5, 1'b1);
      fill_random(56);
      add_item(zgrle_pkg::ACTION_FINISH, 16'h0000, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      send_idle_pct = 76;
      rsp_stall_pct = 15;
      fill_random(28);
      add_item(zgrle_pkg::ACTION_SAMPLE, -16'sd2, 1'b1);
      fill_random(28);
      add_item(zgrle_pkg::ACTION_FINISH, 16'h0000, 1'b0);
      wait_idle();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fill_random(20);
      // a longer run of one extreme value, closed by a finish
      add_item(zgrle_pkg::ACTION_FINISH, 16'h0000, 1'b0);
      repeat (12) add_item(zgrle_pkg::ACTION_SAMPLE, 16'sd32767, 1'b0);
      add_item(zgrle_pkg::ACTION_FINISH, 16'h0000, 1'b0);
      wait_idle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ zigzag_elias_gamma_rle_encoder_top.f @@
rtl/core/zgrle_pkg.sv
rtl/core/zgrle_dp.sv
rtl/core/zgrle_ctrl.sv
rtl/core/zigzag_elias_gamma_rle_encoder_top.sv
verif/testbench.sv
